// ----- hdl/tbed_pkg.sv -----
`default_nettype none
package tbed_pkg;

    localparam int WINDOW_FRAMES_DEF  = 10;
    localparam int TRANSFORM_SIZE_DEF = 2048;
    localparam int QUEUE_DEPTH        = 2;

    localparam int BIN_W   = 10;
    localparam int CPLX_W  = 24;
    localparam int MAG_W   = 40;
    localparam int SUM_W   = 40;
    localparam int NSUM_W  = 34;
    localparam int FLOOR_W = 32;
    localparam int STAMP_W = 32;
    localparam int SNR_W   = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BAND_CENTRE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SPAN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_RATE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_MINIMUM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_GAIN = 3'd4;

    localparam logic [9:0]  CENTER_RESET = 10'd170;
    localparam logic [5:0]  SPAN_RESET   = 6'd8;
    localparam logic [15:0] RATE_RESET   = 16'd1311;
    localparam logic [15:0] MIN_RESET    = 16'd7;
    localparam logic [7:0]  GAIN_RESET   = 8'd32;

    localparam logic [FLOOR_W-1:0] FLOOR_RESET    = 32'd655;
    localparam logic [FLOOR_W-1:0] FALLBACK_NOISE = 32'd66;
    localparam int                 SNR_MIN_SUM    = 6;
    localparam int                 DB_PER_OCTAVE  = 394567;

    typedef struct packed {
        logic [9:0]  band_centre;
        logic [5:0]  half_span;
        logic [15:0] adapt_rate;
        logic [15:0] noise_minimum;
        logic [7:0]  threshold_gain;
    } t_cfg;

    typedef struct packed {
        logic [MAG_W-1:0]   mag;
        logic               band;
        logic [2:0]         hits;
        logic               last;
        logic [STAMP_W-1:0] stamp;
    } t_qent;

endpackage
`default_nettype wire

// ----- hdl/tone_band_energy_detector_top.sv -----
// Per bin: a bin outside the band and noise positions leaves the front idle (one that closes
// the frame waits in the push state), while a bin that contributes goes through two squarings
// and a 32-step root. Frame close: the back end's time is set by the serial divider and the
// shared log2 unit; the bin queue lets the front keep taking bins until the queue is full.
// One result per frame from the output register, held while stalled. Synchronous reset
// restores register defaults and a floor of 655; history is subtracted only in a full window.
`default_nettype none
module tone_band_energy_detector_top #(
    parameter int WINDOW_FRAMES  = tbed_pkg::WINDOW_FRAMES_DEF,
    parameter int TRANSFORM_SIZE = tbed_pkg::TRANSFORM_SIZE_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tbed_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tbed_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [tbed_pkg::BIN_W-1:0]         i_bin_index,
    input  wire logic signed [tbed_pkg::CPLX_W-1:0] i_bin_re,
    input  wire logic signed [tbed_pkg::CPLX_W-1:0] i_bin_im,
    input  wire logic                               i_frame_last,
    input  wire logic [tbed_pkg::STAMP_W-1:0]       i_frame_time,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [tbed_pkg::SUM_W-1:0]              o_window_energy,
    output logic signed [tbed_pkg::SNR_W-1:0]       o_snr_db,
    output logic [tbed_pkg::FLOOR_W-1:0]            o_noise_level,
    output logic [tbed_pkg::STAMP_W-1:0]            o_stamp_out,
    output logic                                    o_detected
);
    import tbed_pkg::*;

    t_cfg  r_cfg;
    t_qent w_push_entry, w_pop_entry;
    logic  w_push, w_full, w_pop, w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_centre    <= CENTER_RESET;
            r_cfg.half_span      <= SPAN_RESET;
            r_cfg.adapt_rate     <= RATE_RESET;
            r_cfg.noise_minimum  <= MIN_RESET;
            r_cfg.threshold_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BAND_CENTRE:    r_cfg.band_centre    <= i_cfg_data[9:0];
                CFG_HALF_SPAN:      r_cfg.half_span      <= i_cfg_data[5:0];
                CFG_ADAPT_RATE:     r_cfg.adapt_rate     <= i_cfg_data;
                CFG_NOISE_MINIMUM:  r_cfg.noise_minimum  <= i_cfg_data;
                CFG_THRESHOLD_GAIN: r_cfg.threshold_gain <= i_cfg_data[7:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    tbed_front #(
        .TRANSFORM_SIZE (TRANSFORM_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_bin_index  (i_bin_index),
        .i_bin_re     (i_bin_re),
        .i_bin_im     (i_bin_im),
        .i_frame_last (i_frame_last),
        .i_frame_time (i_frame_time),
        .o_push       (w_push),
        .o_entry      (w_push_entry),
        .i_full       (w_full)
    );

    tbed_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_empty (w_empty)
    );

    tbed_back #(
        .WINDOW_FRAMES (WINDOW_FRAMES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_empty         (w_empty),
        .i_entry         (w_pop_entry),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_window_energy (o_window_energy),
        .o_snr_db        (o_snr_db),
        .o_noise_level   (o_noise_level),
        .o_stamp_out     (o_stamp_out),
        .o_detected      (o_detected)
    );
endmodule
`default_nettype wire

// ----- hdl/tbed_ram.sv -----
`default_nettype none
module tbed_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 10
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- hdl/tbed_fifo.sv -----
`default_nettype none
module tbed_fifo #(
    parameter int DEPTH = tbed_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  tbed_pkg::t_qent      i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output tbed_pkg::t_qent      o_entry,
    output logic                 o_empty
);
    import tbed_pkg::*;

    localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_qent            r_q [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hdl/tbed_front.sv -----
`default_nettype none
module tbed_front #(
    parameter int TRANSFORM_SIZE = tbed_pkg::TRANSFORM_SIZE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  tbed_pkg::t_cfg                    i_cfg,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [tbed_pkg::BIN_W-1:0]   i_bin_index,
    input  wire logic signed [tbed_pkg::CPLX_W-1:0] i_bin_re,
    input  wire logic signed [tbed_pkg::CPLX_W-1:0] i_bin_im,
    input  wire logic                         i_frame_last,
    input  wire logic [tbed_pkg::STAMP_W-1:0] i_frame_time,
    output logic                              o_push,
    output tbed_pkg::t_qent                   o_entry,
    input  wire logic                         i_full
);
    import tbed_pkg::*;

    localparam int          TS_LOG2 = $clog2(TRANSFORM_SIZE);
    localparam logic [10:0] HALF    = 11'(TRANSFORM_SIZE / 2);

    typedef enum logic [2:0] {F_IDLE, F_SQA, F_SQB, F_ROOT, F_PUSH} t_fstate;

    t_fstate            r_state;
    logic [CPLX_W-1:0]  r_a, r_b;
    logic [47:0]        r_sq;
    logic [63:0]        r_x;
    logic [34:0]        r_rem;
    logic [31:0]        r_root;
    logic [4:0]         r_cnt;
    logic               r_band, r_last;
    logic [2:0]         r_hits;
    logic [STAMP_W-1:0] r_stamp;

    logic signed [11:0] w_d, w_sp;
    logic signed [12:0] w_c, w_b, w_s1, w_s2, w_s3;
    logic               w_in_band, w_lower, w_contrib;
    logic [3:0]         w_hit_vec;
    logic [2:0]         w_hits;
    logic [CPLX_W-1:0]  w_a, w_b_abs;
    logic [47:0]        w_s;
    logic [34:0]        w_rem_sh, w_trial;

    // band and noise classification of the incoming bin
    always_comb begin
        w_d  = $signed({2'b0, i_bin_index}) - $signed({2'b0, i_cfg.band_centre});
        w_sp = $signed({6'b0, i_cfg.half_span});
        w_in_band = (w_d <= w_sp) && (w_d >= -w_sp);
        w_c  = $signed({3'b0, i_cfg.band_centre});
        w_b  = $signed({3'b0, i_bin_index});
        w_s1 = $signed({7'b0, i_cfg.half_span});
        w_s2 = w_s1 <<< 1;
        w_s3 = w_s2 + w_s1;
        w_hit_vec[0] = (w_c - w_s3) == w_b;
        w_hit_vec[1] = (w_c - w_s2) == w_b;
        w_hit_vec[2] = (w_c + w_s2) == w_b;
        w_hit_vec[3] = (w_c + w_s3) == w_b;
        w_hits = {2'b0, w_hit_vec[0]} + {2'b0, w_hit_vec[1]}
               + {2'b0, w_hit_vec[2]} + {2'b0, w_hit_vec[3]};
        w_lower   = {1'b0, i_bin_index} < HALF;
        w_contrib = w_lower && (w_in_band || (w_hits != 3'd0));
        w_a     = i_bin_re[CPLX_W-1] ? (~i_bin_re + 1'b1) : i_bin_re;
        w_b_abs = i_bin_im[CPLX_W-1] ? (~i_bin_im + 1'b1) : i_bin_im;
    end

    assign w_s      = r_sq + r_b * r_b;
    assign w_rem_sh = {r_rem[32:0], r_x[63:62]};
    assign w_trial  = {1'b0, r_root, 2'b01};

    assign o_in_stall    = (r_state != F_IDLE);
    assign o_push        = (r_state == F_PUSH) && !i_full;
    assign o_entry.mag   = MAG_W'({r_root, 8'b0} >> TS_LOG2);
    assign o_entry.band  = r_band;
    assign o_entry.hits  = r_hits;
    assign o_entry.last  = r_last;
    assign o_entry.stamp = r_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_a     <= w_a;
                        r_b     <= w_b_abs;
                        r_band  <= w_lower && w_in_band;
                        r_hits  <= w_lower ? w_hits : 3'd0;
                        r_last  <= i_frame_last;
                        r_stamp <= i_frame_time;
                        r_root  <= '0;
                        if (w_contrib) begin
                            r_state <= F_SQA;
                        end else if (i_frame_last) begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_SQA: begin
                    r_sq    <= r_a * r_a;
                    r_state <= F_SQB;
                end
                F_SQB: begin
                    r_x     <= {w_s, 16'b0};
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= F_ROOT;
                end
                F_ROOT: begin
                    // one result bit per cycle
                    if (w_rem_sh >= w_trial) begin
                        r_rem  <= w_rem_sh - w_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_x   <= {r_x[61:0], 2'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hdl/tbed_log2.sv -----
`default_nettype none
module tbed_log2 #(
    parameter int VAL_W = 44
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [VAL_W-1:0]             i_value,
    output logic                              o_done,
    output logic [$clog2(VAL_W)+16-1:0]       o_result
);
    localparam int EW = $clog2(VAL_W);

    typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_SQ, LG_FIX} t_lstate;

    t_lstate          r_state;
    logic [VAL_W-1:0] r_x;
    logic [EW-1:0]    r_e;
    logic [31:0]      r_m;
    logic [63:0]      r_prod;
    logic [15:0]      r_frac;
    logic [3:0]       r_cnt;
    logic             r_done;
    logic [32:0]      w_t;

    assign w_t      = r_prod[63:31];
    assign o_done   = r_done;
    assign o_result = {r_e, r_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == LG_FIX) && (r_cnt == 4'd15);
            case (r_state)
                LG_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_value;
                        r_e     <= EW'(VAL_W - 1);
                        r_state <= LG_NORM;
                    end
                end
                LG_NORM: begin
                    // shift until the leading one reaches the top or the exponent reaches zero
                    if (r_x[VAL_W-1] || r_e == '0) begin
                        r_m     <= r_x[VAL_W-1 -: 32];
                        r_frac  <= '0;
                        r_cnt   <= '0;
                        r_state <= LG_SQ;
                    end else begin
                        r_x <= {r_x[VAL_W-2:0], 1'b0};
                        r_e <= r_e - 1'b1;
                    end
                end
                LG_SQ: begin
                    r_prod  <= r_m * r_m;
                    r_state <= LG_FIX;
                end
                LG_FIX: begin
                    if (w_t[32]) begin
                        r_m    <= w_t[32:1];
                        r_frac <= {r_frac[14:0], 1'b1};
                    end else begin
                        r_m    <= w_t[31:0];
                        r_frac <= {r_frac[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) begin
                        r_state <= LG_IDLE;
                    end else begin
                        r_state <= LG_SQ;
                    end
                end
                default: r_state <= LG_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hdl/tbed_back.sv -----
`default_nettype none
module tbed_back #(
    parameter int WINDOW_FRAMES = tbed_pkg::WINDOW_FRAMES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  tbed_pkg::t_cfg                     i_cfg,
    input  wire logic                          i_empty,
    input  tbed_pkg::t_qent                    i_entry,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [tbed_pkg::SUM_W-1:0]         o_window_energy,
    output logic signed [tbed_pkg::SNR_W-1:0]  o_snr_db,
    output logic [tbed_pkg::FLOOR_W-1:0]       o_noise_level,
    output logic [tbed_pkg::STAMP_W-1:0]       o_stamp_out,
    output logic                               o_detected
);
    import tbed_pkg::*;

    localparam int CW      = $clog2(WINDOW_FRAMES + 1);
    localparam int TOTAL_W = SUM_W + CW;
    localparam int NS_W    = FLOOR_W + CW;
    localparam int SLOT_W  = WINDOW_FRAMES > 1 ? $clog2(WINDOW_FRAMES) : 1;
    localparam int CMP_W   = TOTAL_W + 4;
    localparam int EW      = $clog2(TOTAL_W);
    localparam int L_W     = EW + 16;
    localparam int D_W     = L_W + 1;
    localparam int P_W     = D_W + 20;

    localparam logic [CW-1:0]     W_CNT     = CW'(WINDOW_FRAMES);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_FRAMES - 1);
    localparam logic [NS_W-1:0]   MIN_SUM   = NS_W'(SNR_MIN_SUM);
    localparam logic [SUM_W-1:0]  MAX40     = '1;
    localparam logic [42:0]       MAX34     = 43'h3_FFFF_FFFF;
    localparam logic [FLOOR_W-1:0] MAX32    = '1;
    localparam logic signed [19:0] DB_K     = 20'(DB_PER_OCTAVE);
    localparam logic signed [P_W-1:0] HALF_LSB = P_W'(1) <<< 23;
    localparam logic signed [P_W-1:0] SNR_MAX  = P_W'(32767);
    localparam logic signed [P_W-1:0] SNR_MIN  = -(P_W'(32768));

    typedef enum logic [3:0] {
        B_IDLE, B_DIV, B_FLT1, B_FLT2, B_HIST, B_CMP1, B_CMP2,
        B_LOGA, B_LOGB, B_SNR, B_EMIT
    } t_bstate;

    t_bstate              r_state;
    logic [SUM_W-1:0]     r_band_sum;
    logic [NSUM_W-1:0]    r_noise_sum;
    logic [2:0]           r_noise_hits;
    logic [STAMP_W-1:0]   r_stamp;
    logic [NSUM_W-1:0]    r_div_n, r_div_q;
    logic [3:0]           r_div_rem;
    logic [5:0]           r_cnt;
    logic [FLOOR_W-1:0]   r_fnoise, r_floor;
    logic                 r_dir, r_above;
    logic [47:0]          r_prod;
    logic [SLOT_W-1:0]    r_slot;
    logic [CW-1:0]        r_fill;
    logic [TOTAL_W-1:0]   r_total;
    logic [39:0]          r_gf;
    logic [NS_W-1:0]      r_nsum;
    logic [L_W-1:0]       r_l_total;
    logic signed [P_W-1:0] r_p;
    logic signed [SNR_W-1:0] r_snr;

    logic                 r_out_valid, r_detected;
    logic [SUM_W-1:0]     r_window_energy;
    logic signed [SNR_W-1:0] r_snr_db;
    logic [FLOOR_W-1:0]   r_noise_level;
    logic [STAMP_W-1:0]   r_stamp_out;

    logic [40:0]          w_band_add;
    logic [42:0]          w_hm, w_noise_add;
    logic [3:0]           w_hits_add;
    logic [3:0]           w_rem_sh;
    logic                 w_qbit;
    logic [NSUM_W-1:0]    w_q_next;
    logic [FLOOR_W-1:0]   w_d;
    logic [32:0]          w_step;
    logic signed [34:0]   w_f;
    logic [SUM_W-1:0]     w_old;
    logic [TOTAL_W-1:0]   w_total_next;
    logic [CMP_W-1:0]     w_lhs, w_rhs;
    logic                 w_log_start, w_log_done;
    logic [TOTAL_W-1:0]   w_log_value;
    logic [L_W-1:0]       w_log_result;
    logic signed [D_W-1:0] w_diff;
    logic signed [P_W-1:0] w_round;
    logic                 w_emit;

    // per-bin accumulation
    always_comb begin
        w_band_add  = {1'b0, r_band_sum} + {1'b0, i_entry.mag};
        w_hm        = (i_entry.hits[0] ? {3'b0, i_entry.mag} : 43'd0)
                    + (i_entry.hits[1] ? {2'b0, i_entry.mag, 1'b0} : 43'd0)
                    + (i_entry.hits[2] ? {1'b0, i_entry.mag, 2'b0} : 43'd0);
        w_noise_add = {9'b0, r_noise_sum} + w_hm;
        w_hits_add  = {1'b0, r_noise_hits} + {1'b0, i_entry.hits};
    end

    // restoring division of the noise sum by the hit count
    always_comb begin
        w_rem_sh = {r_div_rem[2:0], r_div_n[NSUM_W-1]};
        w_qbit   = w_rem_sh >= {1'b0, r_noise_hits};
        w_q_next = {r_div_q[NSUM_W-2:0], w_qbit};
    end

    assign w_d    = (r_fnoise >= r_floor) ? (r_fnoise - r_floor) : (r_floor - r_fnoise);
    assign w_step = 33'(({1'b0, r_prod} + 49'd32768) >> 16);
    assign w_f    = r_dir ? ($signed({3'b0, r_floor}) + $signed({2'b0, w_step}))
                          : ($signed({3'b0, r_floor}) - $signed({2'b0, w_step}));

    assign w_total_next = ((r_fill >= W_CNT) ? (r_total - {{CW{1'b0}}, w_old}) : r_total)
                        + {{CW{1'b0}}, r_band_sum};

    assign w_lhs = {r_total, 4'b0};
    assign w_rhs = CMP_W'({{CW{1'b0}}, r_gf} * W_CNT);

    assign w_log_start = (r_state == B_CMP2 && r_nsum > MIN_SUM && r_total != '0)
                       || (r_state == B_LOGA && w_log_done);
    assign w_log_value = (r_state == B_CMP2) ? r_total : TOTAL_W'(r_nsum);
    assign w_diff      = $signed({1'b0, r_l_total}) - $signed({1'b0, w_log_result});

    always_comb begin
        if (!r_p[P_W-1]) begin
            w_round = (r_p + HALF_LSB) >>> 24;
        end else begin
            w_round = -(P_W'(($unsigned(-r_p) + $unsigned(HALF_LSB)) >> 24));
        end
    end

    assign w_emit = (r_state == B_EMIT) && (!r_out_valid || !i_out_stall);
    assign o_pop  = (r_state == B_IDLE) && !i_empty;

    tbed_ram #(
        .WIDTH (SUM_W),
        .DEPTH (WINDOW_FRAMES)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (r_state == B_HIST),
        .i_waddr (r_slot),
        .i_wdata (r_band_sum),
        .i_raddr (r_slot),
        .o_rdata (w_old)
    );

    tbed_log2 #(
        .VAL_W (TOTAL_W)
    ) u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_log_start),
        .i_value  (w_log_value),
        .o_done   (w_log_done),
        .o_result (w_log_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_band_sum   <= '0;
            r_noise_sum  <= '0;
            r_noise_hits <= '0;
            r_floor      <= FLOOR_RESET;
            r_above      <= 1'b0;
            r_slot       <= '0;
            r_fill       <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        if (i_entry.band) begin
                            r_band_sum <= w_band_add[40] ? MAX40 : w_band_add[SUM_W-1:0];
                        end
                        if (i_entry.hits != 3'd0) begin
                            r_noise_sum  <= (w_noise_add > MAX34) ? MAX34[NSUM_W-1:0]
                                                                  : w_noise_add[NSUM_W-1:0];
                            r_noise_hits <= w_hits_add[3] ? 3'd7 : w_hits_add[2:0];
                            r_div_n      <= (w_noise_add > MAX34) ? MAX34[NSUM_W-1:0]
                                                                  : w_noise_add[NSUM_W-1:0];
                        end else begin
                            r_div_n <= r_noise_sum;
                        end
                        if (i_entry.last) begin
                            r_stamp   <= i_entry.stamp;
                            r_div_rem <= '0;
                            r_div_q   <= '0;
                            r_cnt     <= '0;
                            r_state   <= B_DIV;
                        end
                    end
                end
                B_DIV: begin
                    r_div_rem <= w_qbit ? (w_rem_sh - {1'b0, r_noise_hits}) : w_rem_sh;
                    r_div_n   <= {r_div_n[NSUM_W-2:0], 1'b0};
                    r_div_q   <= w_q_next;
                    r_cnt     <= r_cnt + 1'b1;
                    if (r_cnt == 6'(NSUM_W - 1)) begin
                        if (r_noise_hits == 3'd0) begin
                            r_fnoise <= FALLBACK_NOISE;
                        end else if (w_q_next[NSUM_W-1:FLOOR_W] != '0) begin
                            r_fnoise <= MAX32;
                        end else begin
                            r_fnoise <= w_q_next[FLOOR_W-1:0];
                        end
                        r_state <= B_FLT1;
                    end
                end
                B_FLT1: begin
                    r_dir   <= r_fnoise >= r_floor;
                    r_prod  <= w_d * i_cfg.adapt_rate;
                    r_state <= B_FLT2;
                end
                B_FLT2: begin
                    // the floor holds while the previous frame was above threshold
                    if (!r_above) begin
                        if (w_f < $signed({19'b0, i_cfg.noise_minimum})) begin
                            r_floor <= {16'b0, i_cfg.noise_minimum};
                        end else if (w_f > $signed({3'b0, MAX32})) begin
                            r_floor <= MAX32;
                        end else begin
                            r_floor <= w_f[FLOOR_W-1:0];
                        end
                    end
                    r_state <= B_HIST;
                end
                B_HIST: begin
                    r_total <= w_total_next;
                    r_slot  <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                    if (r_fill < W_CNT) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= B_CMP1;
                end
                B_CMP1: begin
                    r_gf    <= i_cfg.threshold_gain * r_floor;
                    r_nsum  <= {{CW{1'b0}}, r_floor} * W_CNT;
                    r_state <= B_CMP2;
                end
                B_CMP2: begin
                    r_above <= w_lhs > w_rhs;
                    if (r_nsum <= MIN_SUM) begin
                        r_snr   <= '0;
                        r_state <= B_EMIT;
                    end else if (r_total == '0) begin
                        r_snr   <= SNR_MIN[SNR_W-1:0];
                        r_state <= B_EMIT;
                    end else begin
                        r_state <= B_LOGA;
                    end
                end
                B_LOGA: begin
                    if (w_log_done) begin
                        r_l_total <= w_log_result;
                        r_state   <= B_LOGB;
                    end
                end
                B_LOGB: begin
                    if (w_log_done) begin
                        r_p     <= w_diff * DB_K;
                        r_state <= B_SNR;
                    end
                end
                B_SNR: begin
                    if (w_round > SNR_MAX) begin
                        r_snr <= SNR_MAX[SNR_W-1:0];
                    end else if (w_round < SNR_MIN) begin
                        r_snr <= SNR_MIN[SNR_W-1:0];
                    end else begin
                        r_snr <= w_round[SNR_W-1:0];
                    end
                    r_state <= B_EMIT;
                end
                B_EMIT: begin
                    if (w_emit) begin
                        r_out_valid     <= 1'b1;
                        r_window_energy <= (r_total > {{CW{1'b0}}, MAX40}) ? MAX40
                                                                          : r_total[SUM_W-1:0];
                        r_snr_db        <= r_snr;
                        r_noise_level   <= r_floor;
                        r_stamp_out     <= r_stamp;
                        r_detected      <= r_above;
                        r_band_sum      <= '0;
                        r_noise_sum     <= '0;
                        r_noise_hits    <= '0;
                        r_state         <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_window_energy = r_window_energy;
    assign o_snr_db        = r_snr_db;
    assign o_noise_level   = r_noise_level;
    assign o_stamp_out     = r_stamp_out;
    assign o_detected      = r_detected;
endmodule
`default_nettype wire

// ----- hdl/tbed_checker.sv -----
`default_nettype none
module tbed_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [39:0] o_window_energy,
    input wire logic [15:0] o_snr_db,
    input wire logic [31:0] o_stamp_out,
    input wire logic        o_detected
);
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_out_valid) && $past(i_out_stall) |-> o_out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_out_valid) && $past(i_out_stall)
        |-> $stable(o_window_energy) && $stable(o_snr_db) && $stable(o_stamp_out))
        else $error("stalled result changed");

    a_detect_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_detected |-> o_window_energy != 40'd0)
        else $error("detection with empty window");

    a_empty_snr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_window_energy == 40'd0
        |-> (o_snr_db == 16'h8000 || o_snr_db == 16'h0000))
        else $error("snr of empty window is neither floor nor zero");
endmodule

bind tone_band_energy_detector_top tbed_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_window_energy (o_window_energy),
    .o_snr_db        (o_snr_db),
    .o_stamp_out     (o_stamp_out),
    .o_detected      (o_detected)
);
`default_nettype wire

// ----- dv/tone_band_energy_detector_top_tb.sv -----
`default_nettype none
module tone_band_energy_detector_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tbed_pkg::*;

    localparam int WIN   = WINDOW_FRAMES_DEF;
    localparam int NFFT  = TRANSFORM_SIZE_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    typedef struct packed {
        logic [SUM_W-1:0]   energy;
        logic [SNR_W-1:0]   snr;
        logic [FLOOR_W-1:0] level;
        logic [STAMP_W-1:0] stamp;
        logic               hit;
    } t_frame_res;

    int n_errors = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Band energy predictor: mirrors the block state and holds pending frame results.
    class band_energy_sb;
        t_cfg             cfg;
        logic [43:0]      history [WIN];
        int               slot, filled;
        logic [63:0]      total;
        logic [63:0]      floor_est;
        bit               above;
        logic [63:0]      band_acc, noise_acc, noise_cnt;
        t_frame_res       pending [$];
        int               n_frames, n_detects;

        function new();
            cfg = '{CENTER_RESET, SPAN_RESET, RATE_RESET, MIN_RESET, GAIN_RESET};
            foreach (history[i]) history[i] = '0;
            slot = 0; filled = 0; total = 0; floor_est = FLOOR_RESET; above = 0;
            band_acc = 0; noise_acc = 0; noise_cnt = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
            case (idx)
                CFG_BAND_CENTRE:    cfg.band_centre = v[9:0];
                CFG_HALF_SPAN:      cfg.half_span = v[5:0];
                CFG_ADAPT_RATE:     cfg.adapt_rate = v;
                CFG_NOISE_MINIMUM:  cfg.noise_minimum = v;
                CFG_THRESHOLD_GAIN: cfg.threshold_gain = v[7:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] r, b;
            r = 0; b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b; r = (r >> 1) + b;
                end else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint log2_fix(logic [63:0] v);
            int e;
            logic [63:0] m, fr;
            e = 63; fr = 0;
            while (e > 0 && v[e] == 1'b0) e--;
            m = (e <= 31) ? (v << (31 - e)) : (v >> (e - 31));
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 31;
                fr <<= 1;
                if (m >= (64'd1 << 32)) begin
                    fr |= 1; m >>= 1;
                end
            end
            return longint'(e) * 65536 + longint'(fr);
        endfunction

        function void note_bin(logic [9:0] bin, logic signed [23:0] re,
                               logic signed [23:0] im, logic last, logic [31:0] stamp);
            logic [63:0] a, b, mag, fnoise, nsum, hits;
            longint d, sp, f, p, snr;
            t_frame_res r;
            if (bin < NFFT / 2) begin
                a = re < 0 ? 64'(-longint'(re)) : 64'(re);
                b = im < 0 ? 64'(-longint'(im)) : 64'(im);
                mag = (int_sqrt((a * a + b * b) << 16) << 8) / NFFT;
                d = longint'(bin) - longint'(cfg.band_centre);
                sp = longint'(cfg.half_span);
                if (d <= sp && d >= -sp) begin
                    band_acc += mag;
                    if (band_acc > 64'hFF_FFFF_FFFF) band_acc = 64'hFF_FFFF_FFFF;
                end
                hits = 0;
                if (d == -3 * sp) hits++;
                if (d == -2 * sp) hits++;
                if (d == 2 * sp) hits++;
                if (d == 3 * sp) hits++;
                if (hits != 0) begin
                    noise_acc += hits * mag;
                    if (noise_acc > 64'h3_FFFF_FFFF) noise_acc = 64'h3_FFFF_FFFF;
                    noise_cnt += hits;
                    if (noise_cnt > 7) noise_cnt = 7;
                end
            end
            if (!last) return;
            if (noise_cnt != 0) begin
                fnoise = noise_acc / noise_cnt;
                if (fnoise > 64'hFFFF_FFFF) fnoise = 64'hFFFF_FFFF;
            end else fnoise = FALLBACK_NOISE;
            if (!above) begin
                f = longint'(floor_est);
                if (fnoise >= floor_est)
                    f += longint'(((fnoise - floor_est) * cfg.adapt_rate + 32768) >> 16);
                else
                    f -= longint'(((floor_est - fnoise) * cfg.adapt_rate + 32768) >> 16);
                if (f < longint'(cfg.noise_minimum)) f = longint'(cfg.noise_minimum);
                if (f > 64'hFFFF_FFFF) f = 64'hFFFF_FFFF;
                floor_est = 64'(f);
            end
            if (filled >= WIN) total -= history[slot];
            history[slot] = band_acc[43:0];
            total += band_acc;
            slot = (slot + 1) % WIN;
            if (filled < WIN) filled++;
            above = total * 16 > cfg.threshold_gain * floor_est * WIN;
            nsum = floor_est * WIN;
            if (nsum <= SNR_MIN_SUM) snr = 0;
            else if (total == 0) snr = -32768;
            else begin
                p = (log2_fix(total) - log2_fix(nsum)) * DB_PER_OCTAVE;
                if (p >= 0) snr = (p + (64'sd1 <<< 23)) >>> 24;
                else snr = -((-p + (64'sd1 <<< 23)) >>> 24);
                if (snr > 32767) snr = 32767;
                if (snr < -32768) snr = -32768;
            end
            r.energy = total > 64'hFF_FFFF_FFFF ? 40'hFF_FFFF_FFFF : total[39:0];
            r.snr = snr[15:0];
            r.level = floor_est[31:0];
            r.stamp = stamp;
            r.hit = above;
            pending.push_back(r);
            n_frames++;
            if (above) n_detects++;
            band_acc = 0; noise_acc = 0; noise_cnt = 0;
        endfunction

        task check_result(t_frame_res got);
            t_frame_res w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result, stamp", got.stamp, 0);
                return;
            end
            w = pending.pop_front();
            if (got.energy !== w.energy) report_mismatch("window_energy", got.energy, w.energy);
            if (got.snr !== w.snr) report_mismatch("snr_db", got.snr, w.snr);
            if (got.level !== w.level) report_mismatch("noise_level", got.level, w.level);
            if (got.stamp !== w.stamp) report_mismatch("stamp_out", got.stamp, w.stamp);
            if (got.hit !== w.hit) report_mismatch("detected", got.hit, w.hit);
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 0, o_in_stall;
    logic [BIN_W-1:0] i_bin_index = '0;
    logic signed [CPLX_W-1:0] i_bin_re = '0, i_bin_im = '0;
    logic i_frame_last = 0;
    logic [STAMP_W-1:0] i_frame_time = '0;
    logic o_out_valid, i_out_stall = 1;
    logic [SUM_W-1:0] o_window_energy;
    logic signed [SNR_W-1:0] o_snr_db;
    logic [FLOOR_W-1:0] o_noise_level, o_stamp_out;
    logic o_detected;

    band_energy_sb sb = new();
    int n_bins = 0;
    bit quiet_out = 0;

    always #6 i_clk = ~i_clk;

    tone_band_energy_detector_top dut (.*);

    // Receiver: random stall, check every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{o_window_energy, o_snr_db, o_noise_level, o_stamp_out,
                              o_detected});
    end

    initial begin
        int w;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = quiet_out ? 0 : $urandom_range(0, 17);
            if (w == 0) begin
                i_out_stall <= 0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= 1;
                repeat (w) @(posedge i_clk);
            end
        end
    end

    task automatic send_bin(input logic [9:0] bin, input logic signed [23:0] re,
                            input logic signed [23:0] im, input logic last,
                            input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_bin_index <= bin;
        i_bin_re <= re;
        i_bin_im <= im;
        i_frame_last <= last;
        i_frame_time <= $urandom;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_bin(bin, re, im, last, i_frame_time);
        n_bins++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        i_in_valid <= 0;
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, v);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        // back end may still be on a bin with no result pending
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_cplx(int kind);
        case (kind)
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'(int'($urandom_range(0, 64)) - 32);
            default: return 24'($urandom);
        endcase
    endfunction

    // One frame: band bins, noise bins, optional strays, last one closes the frame.
    task automatic send_frame(input int n_extra, input int amp);
        int c, s, n, idx;
        logic [9:0] bin;
        c = sb.cfg.band_centre;
        s = sb.cfg.half_span;
        n = $urandom_range(2, 8) + n_extra;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0, 1: idx = c + int'($urandom_range(0, 2 * s)) - s;
                2:    idx = c + (($urandom_range(0, 1)) ? 1 : -1) * s *
                            int'($urandom_range(2, 3));
                3:    idx = $urandom_range(1024, 1023 + 1024) - 1024 + 1024;
                default: idx = $urandom_range(0, 1023);
            endcase
            bin = idx[9:0];
            send_bin(bin, amp == 4 ? rand_cplx($urandom_range(0, 3)) :
                          24'(int'($urandom_range(0, amp * 2000)) - amp * 1000),
                     rand_cplx($urandom_range(2, 3)), i == n - 1, 0);
        end
    endtask

    initial begin
        i_rst_n <= 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes, band edges, noise positions, strays, empty frame
        send_bin(10'd170, 24'sh7FFFFF, 24'sh7FFFFF, 0, 1);
        send_bin(10'd170, 24'sh800000, 24'sh800000, 0, 1);
        send_bin(10'd162, 24'sh000001, 24'sh000000, 0, 0);
        send_bin(10'd178, 24'shFFFFFF, 24'sh555555, 0, 0);
        send_bin(10'd154, 24'sh123456, 24'shAAAAAA, 0, 0);
        send_bin(10'd146, 24'sh001000, 24'sh000000, 0, 0);
        send_bin(10'd186, 24'sh000000, 24'sh001000, 0, 0);
        send_bin(10'd194, 24'sh7FFFFF, 24'sh000000, 0, 0);
        send_bin(10'd0, 24'sh000000, 24'sh000000, 0, 0);
        send_bin(10'd1023, 24'sh7FFFFF, 24'sh7FFFFF, 1, 0);
        send_bin(10'd500, 24'sh000000, 24'sh000000, 1, 0);
        send_bin(10'd161, 24'sh000100, 24'sh000000, 1, 0);
        drain();

        // half_span 0: all noise positions hit the centre
        write_reg(CFG_HALF_SPAN, 16'd0);
        write_reg(CFG_BAND_CENTRE, 16'd0);
        write_reg(CFG_NO_REG, 16'hFFFF);
        send_bin(10'd0, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0);
        send_bin(10'd0, 24'sh7FFFFF, 24'sh7FFFFF, 1, 0);
        drain();

        // random phases across several settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_BAND_CENTRE, 16'd1023); write_reg(CFG_HALF_SPAN, 16'd63);
                    write_reg(CFG_ADAPT_RATE, 16'hFFFF); write_reg(CFG_NOISE_MINIMUM, 16'd0);
                    write_reg(CFG_THRESHOLD_GAIN, 16'd255);
                end
                1: begin
                    write_reg(CFG_BAND_CENTRE, 16'd170); write_reg(CFG_HALF_SPAN, 16'd1);
                    write_reg(CFG_ADAPT_RATE, 16'd0); write_reg(CFG_NOISE_MINIMUM, 16'hFFFF);
                    write_reg(CFG_THRESHOLD_GAIN, 16'd0);
                end
                2: begin
                    write_reg(CFG_BAND_CENTRE, 16'd512); write_reg(CFG_HALF_SPAN, 16'd8);
                    write_reg(CFG_ADAPT_RATE, 16'd1311); write_reg(CFG_NOISE_MINIMUM, 16'd7);
                    write_reg(CFG_THRESHOLD_GAIN, 16'd32);
                end
                default: begin
                    write_reg(CFG_BAND_CENTRE, 16'($urandom_range(0, 1023)));
                    write_reg(CFG_HALF_SPAN, 16'($urandom_range(1, 63)));
                    write_reg(CFG_ADAPT_RATE, 16'($urandom));
                    write_reg(CFG_NOISE_MINIMUM, 16'($urandom_range(0, 300)));
                    write_reg(CFG_THRESHOLD_GAIN, 16'($urandom_range(0, 255)));
                end
            endcase
            quiet_out = (ph == 5);
            for (int fr = 0; fr < 32; fr++)
                send_frame(0, $urandom_range(1, 4));
            drain();
        end
        $display("covered %0d bins in %0d frames, %0d detections, over 8 register settings",
                 n_bins, sb.n_frames, sb.n_detects);
        if (n_errors == 0)
            $display("tone_band_energy_detector_top_tb: PASS");
        else
            $display("tone_band_energy_detector_top_tb: FAIL");
        $finish;
    end

    initial begin
        #40ms;
        $display("tone_band_energy_detector_top_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
hdl/tbed_pkg.sv
hdl/tbed_ram.sv
hdl/tbed_fifo.sv
hdl/tbed_front.sv
hdl/tbed_log2.sv
hdl/tbed_back.sv
hdl/tone_band_energy_detector_top.sv
hdl/tbed_checker.sv
dv/tone_band_energy_detector_top_tb.sv
